@@ hdl/bfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdm_pkg
// Shared types and constants for the dense-matrix shortest-path solver.
// ----------------------------------------------------------------------------
package bfdm_pkg;

  localparam int COST_W = 64;
  localparam int NODE_W = 6;
  localparam int PRED_W = 7;
  localparam int ITER_W = 7;
  localparam int CFG_W  = 7;

  // The largest signed cost marks a missing edge and an unreached node.
  localparam logic signed [COST_W-1:0] NO_EDGE = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] ZERO_COST = '0;

  // Predecessor code for a node with no predecessor (minus one).
  localparam logic [PRED_W-1:0] PRED_NONE = '1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_EDGE_RD,
    ST_EDGE_UPD,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_ROW,
    RD_EDGE,
    RD_OUT
  } rd_sel_t;

  typedef struct packed {
    logic    mat_ld;
    logic    mat_rd;
    logic    best_rd;
    rd_sel_t rd_sel;
    logic    clr_we;
    logic    upd_en;
    logic    du_ld;
    logic    out_ld;
    logic    out_last;
  } ctrl_t;

  typedef struct packed {
    logic du_unreached;
    logic take;
  } stat_t;

endpackage

@@ hdl/bfdm_ifs.sv @@
// ----------------------------------------------------------------------------
// bfdm_ifs
// Valid/ready channels for requests into and results out of the solver.
// ----------------------------------------------------------------------------
interface bfdm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic        [bfdm_pkg::NODE_W-1:0]       src_node;
  logic        [bfdm_pkg::NODE_W-1:0]       dst_node;
  logic signed [bfdm_pkg::COST_W-1:0]       edge_cost;

  modport source (output valid, mode, src_node, dst_node, edge_cost, input ready);
  modport sink   (input valid, mode, src_node, dst_node, edge_cost, output ready);
endinterface

interface bfdm_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [bfdm_pkg::NODE_W-1:0]       node;
  logic signed [bfdm_pkg::COST_W-1:0]       min_cost;
  logic signed [bfdm_pkg::PRED_W-1:0]       predecessor;
  logic        [bfdm_pkg::ITER_W-1:0]       iterations;
  logic                                     costs_valid;
  logic                                     last;

  modport source (output valid, node, min_cost, predecessor, iterations, costs_valid, last,
                  input ready);
  modport sink   (input valid, node, min_cost, predecessor, iterations, costs_valid, last,
                  output ready);
endinterface

@@ hdl/bfdm_relax.sv @@
// ----------------------------------------------------------------------------
// bfdm_relax
// Shared relaxation unit: one 64-bit add with overflow check and compare.
// ----------------------------------------------------------------------------
module bfdm_relax (
  input  logic signed [bfdm_pkg::COST_W-1:0] du,
  input  logic signed [bfdm_pkg::COST_W-1:0] w,
  input  logic signed [bfdm_pkg::COST_W-1:0] dv,
  output logic signed [bfdm_pkg::COST_W-1:0] sum,
  output logic                               take
);

  logic ovf;

  always_comb begin
    sum = du + w;
    // Overflow only when both operands share a sign that the sum lacks.
    ovf = (du[bfdm_pkg::COST_W-1] == w[bfdm_pkg::COST_W-1]) &&
          (sum[bfdm_pkg::COST_W-1] != du[bfdm_pkg::COST_W-1]);
    take = (w != bfdm_pkg::NO_EDGE) && !ovf && (sum < dv);
  end

endmodule

@@ hdl/bfdm_data.sv @@
// ----------------------------------------------------------------------------
// bfdm_data
// Cost matrix, best-cost and predecessor memories, and the result register.
// ----------------------------------------------------------------------------
module bfdm_data #(
  parameter  int MAX_NODES = 64,
  localparam int IW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1),
  localparam int AW = $clog2(MAX_NODES * MAX_NODES)
) (
  input  logic                                clk,
  input  bfdm_pkg::ctrl_t                     ctrl,
  output bfdm_pkg::stat_t                     stat,
  input  logic [IW-1:0]                       u_idx,
  input  logic [IW-1:0]                       v_idx,
  input  logic [IW-1:0]                       i_idx,
  input  logic [CW-1:0]                       pass_cnt,
  input  logic                                changed,
  input  logic [bfdm_pkg::NODE_W-1:0]         ld_src,
  input  logic [bfdm_pkg::NODE_W-1:0]         ld_dst,
  input  logic signed [bfdm_pkg::COST_W-1:0]  ld_cost,
  output logic [bfdm_pkg::NODE_W-1:0]         res_node,
  output logic signed [bfdm_pkg::COST_W-1:0]  res_min_cost,
  output logic signed [bfdm_pkg::PRED_W-1:0]  res_predecessor,
  output logic [bfdm_pkg::ITER_W-1:0]         res_iterations,
  output logic                                res_costs_valid,
  output logic                                res_last
);

  logic signed [bfdm_pkg::COST_W-1:0] mat_mem  [MAX_NODES*MAX_NODES];
  logic signed [bfdm_pkg::COST_W-1:0] cost_mem [MAX_NODES];
  logic        [bfdm_pkg::PRED_W-1:0] prev_mem [MAX_NODES];

  logic signed [bfdm_pkg::COST_W-1:0] mat_q_r;
  logic signed [bfdm_pkg::COST_W-1:0] cost_q_r;
  logic        [bfdm_pkg::PRED_W-1:0] prev_q_r;
  logic signed [bfdm_pkg::COST_W-1:0] du_r;

  logic                               ld_ok;
  logic [AW-1:0]                      ld_addr;
  logic [AW-1:0]                      edge_addr;
  logic [IW-1:0]                      best_raddr;
  logic                               best_we;
  logic [IW-1:0]                      best_waddr;
  logic signed [bfdm_pkg::COST_W-1:0] best_wcost;
  logic        [bfdm_pkg::PRED_W-1:0] best_wprev;
  logic signed [bfdm_pkg::COST_W-1:0] sum;
  logic                               take;

  bfdm_relax u_relax (
    .du   (du_r),
    .w    (mat_q_r),
    .dv   (cost_q_r),
    .sum  (sum),
    .take (take)
  );

  always_comb begin
    ld_ok     = (32'(ld_src) < MAX_NODES) && (32'(ld_dst) < MAX_NODES);
    ld_addr   = AW'(ld_src) * AW'(MAX_NODES) + AW'(ld_dst);
    edge_addr = AW'(u_idx) * AW'(MAX_NODES) + AW'(v_idx);
  end

  always_comb begin
    unique case (ctrl.rd_sel)
      bfdm_pkg::RD_ROW:  best_raddr = u_idx;
      bfdm_pkg::RD_EDGE: best_raddr = v_idx;
      bfdm_pkg::RD_OUT:  best_raddr = i_idx;
      default:           best_raddr = i_idx;
    endcase
  end

  // The clearing sweep and edge updates never overlap, so one write port does.
  always_comb begin
    if (ctrl.clr_we) begin
      best_we    = 1'b1;
      best_waddr = i_idx;
      best_wcost = (i_idx == '0) ? bfdm_pkg::ZERO_COST : bfdm_pkg::NO_EDGE;
      best_wprev = bfdm_pkg::PRED_NONE;
    end else begin
      best_we    = ctrl.upd_en && take;
      best_waddr = v_idx;
      best_wcost = sum;
      best_wprev = bfdm_pkg::PRED_W'(u_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mat_ld && ld_ok) begin
      mat_mem[ld_addr] <= ld_cost;
    end
    if (ctrl.mat_rd) begin
      mat_q_r <= mat_mem[edge_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      cost_mem[best_waddr] <= best_wcost;
      prev_mem[best_waddr] <= best_wprev;
    end
    if (ctrl.best_rd) begin
      cost_q_r <= cost_mem[best_raddr];
      prev_q_r <= prev_mem[best_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.du_ld) begin
      du_r <= cost_q_r;
    end
  end

  always_comb begin
    stat.du_unreached = (cost_q_r == bfdm_pkg::NO_EDGE);
    stat.take         = take;
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      res_node        <= bfdm_pkg::NODE_W'(i_idx);
      res_min_cost    <= changed ? bfdm_pkg::ZERO_COST : cost_q_r;
      res_predecessor <= prev_q_r;
      res_iterations  <= changed ? '0 : bfdm_pkg::ITER_W'(pass_cnt);
      res_costs_valid <= !changed;
      res_last        <= ctrl.out_last;
    end
  end

endmodule

@@ hdl/bfdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfdm_ctrl
// Sequencer: clearing sweep, relaxation passes and result emission.
// ----------------------------------------------------------------------------
module bfdm_ctrl #(
  parameter  int MAX_NODES = 64,
  localparam int IW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_mode,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  input  logic [bfdm_pkg::CFG_W-1:0]  node_count,
  input  bfdm_pkg::stat_t             stat,
  output bfdm_pkg::ctrl_t             ctrl,
  output logic [IW-1:0]               u_idx,
  output logic [IW-1:0]               v_idx,
  output logic [IW-1:0]               i_idx,
  output logic [CW-1:0]               pass_cnt,
  output logic                        changed
);

  bfdm_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    u_r, u_nxt;
  logic [IW-1:0]    v_r, v_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    pass_r, pass_nxt;
  logic             changed_r, changed_nxt;

  logic             in_fire;
  logic             start;
  logic [CW-1:0]    n_sel;
  logic [CW-1:0]    n_last;
  logic [CW-1:0]    pass_inc;
  logic             u_last, v_last, i_last;
  logic             chg_now;
  logic             pass_go;
  logic             row_done;
  bfdm_pkg::state_t row_next;

  always_comb begin
    in_ready  = (state_r == bfdm_pkg::ST_IDLE);
    out_valid = (state_r == bfdm_pkg::ST_OUT_WAIT);
    in_fire   = in_valid && in_ready;
    start     = in_fire && (in_mode == bfdm_pkg::MODE_START);

    if (node_count == '0) begin
      n_sel = CW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_sel = CW'(MAX_NODES);
    end else begin
      n_sel = CW'(node_count);
    end

    n_last   = n_r - CW'(1);
    pass_inc = pass_r + CW'(1);
    u_last   = (CW'(u_r) == n_last);
    v_last   = (CW'(v_r) == n_last);
    i_last   = (CW'(i_r) == n_last);
    chg_now  = changed_r || ((state_r == bfdm_pkg::ST_EDGE_UPD) && stat.take);
    pass_go  = chg_now && (pass_inc < n_r);
    row_done = ((state_r == bfdm_pkg::ST_ROW_CHK) && stat.du_unreached) ||
               ((state_r == bfdm_pkg::ST_EDGE_UPD) && v_last);
    row_next = (u_last && !pass_go) ? bfdm_pkg::ST_OUT_RD : bfdm_pkg::ST_ROW_RD;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfdm_pkg::ST_IDLE: begin
        if (start) state_nxt = bfdm_pkg::ST_CLEAR;
      end
      bfdm_pkg::ST_CLEAR: begin
        if (i_last) state_nxt = bfdm_pkg::ST_ROW_RD;
      end
      bfdm_pkg::ST_ROW_RD: state_nxt = bfdm_pkg::ST_ROW_CHK;
      bfdm_pkg::ST_ROW_CHK: begin
        state_nxt = stat.du_unreached ? row_next : bfdm_pkg::ST_EDGE_RD;
      end
      bfdm_pkg::ST_EDGE_RD: state_nxt = bfdm_pkg::ST_EDGE_UPD;
      bfdm_pkg::ST_EDGE_UPD: begin
        state_nxt = v_last ? row_next : bfdm_pkg::ST_EDGE_RD;
      end
      bfdm_pkg::ST_OUT_RD: state_nxt = bfdm_pkg::ST_OUT_LD;
      bfdm_pkg::ST_OUT_LD: state_nxt = bfdm_pkg::ST_OUT_WAIT;
      bfdm_pkg::ST_OUT_WAIT: begin
        if (out_ready) state_nxt = i_last ? bfdm_pkg::ST_IDLE : bfdm_pkg::ST_OUT_RD;
      end
      default: state_nxt = bfdm_pkg::ST_IDLE;
    endcase
  end

  // Counters and pass bookkeeping.
  always_comb begin
    u_nxt       = u_r;
    v_nxt       = v_r;
    i_nxt       = i_r;
    n_nxt       = n_r;
    pass_nxt    = pass_r;
    changed_nxt = changed_r;

    if (state_r == bfdm_pkg::ST_IDLE && start) begin
      n_nxt = n_sel;
      i_nxt = '0;
    end

    if (state_r == bfdm_pkg::ST_CLEAR) begin
      if (i_last) begin
        i_nxt       = '0;
        u_nxt       = '0;
        pass_nxt    = CW'(1);
        changed_nxt = 1'b0;
      end else begin
        i_nxt = i_r + IW'(1);
      end
    end

    if (state_r == bfdm_pkg::ST_ROW_CHK && !stat.du_unreached) begin
      v_nxt = '0;
    end

    if (state_r == bfdm_pkg::ST_EDGE_UPD) begin
      changed_nxt = chg_now;
      if (!v_last) v_nxt = v_r + IW'(1);
    end

    if (row_done) begin
      if (u_last) begin
        pass_nxt = pass_inc;
        u_nxt    = '0;
        i_nxt    = '0;
        // A new pass starts with a clean change flag; otherwise it is final.
        changed_nxt = pass_go ? 1'b0 : chg_now;
      end else begin
        u_nxt       = u_r + IW'(1);
        changed_nxt = chg_now;
      end
    end

    if (state_r == bfdm_pkg::ST_OUT_WAIT && out_ready && !i_last) begin
      i_nxt = i_r + IW'(1);
    end
  end

  // Control outputs to the datapath.
  always_comb begin
    ctrl.mat_ld   = in_fire && (in_mode == bfdm_pkg::MODE_LOAD);
    ctrl.mat_rd   = (state_r == bfdm_pkg::ST_EDGE_RD);
    ctrl.best_rd  = (state_r == bfdm_pkg::ST_ROW_RD) ||
                    (state_r == bfdm_pkg::ST_EDGE_RD) ||
                    (state_r == bfdm_pkg::ST_OUT_RD);
    ctrl.rd_sel   = (state_r == bfdm_pkg::ST_ROW_RD)  ? bfdm_pkg::RD_ROW  :
                    (state_r == bfdm_pkg::ST_EDGE_RD) ? bfdm_pkg::RD_EDGE :
                                                        bfdm_pkg::RD_OUT;
    ctrl.clr_we   = (state_r == bfdm_pkg::ST_CLEAR);
    ctrl.upd_en   = (state_r == bfdm_pkg::ST_EDGE_UPD);
    ctrl.du_ld    = (state_r == bfdm_pkg::ST_ROW_CHK);
    ctrl.out_ld   = (state_r == bfdm_pkg::ST_OUT_LD);
    ctrl.out_last = i_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfdm_pkg::ST_IDLE;
      u_r       <= '0;
      v_r       <= '0;
      i_r       <= '0;
      n_r       <= CW'(1);
      pass_r    <= CW'(1);
      changed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      u_r       <= u_nxt;
      v_r       <= v_nxt;
      i_r       <= i_nxt;
      n_r       <= n_nxt;
      pass_r    <= pass_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign u_idx    = u_r;
  assign v_idx    = v_r;
  assign i_idx    = i_r;
  assign pass_cnt = pass_r;
  assign changed  = changed_r;

endmodule

@@ hdl/bellman_ford_dense_matrix.sv @@
// Sequence: a load request writes one matrix entry if both nodes are below MAX_NODES.
// A start request clears n best costs, then per pass visits each row and each edge of every
// reached row, for up to max(1, n-1) passes; it then emits n results, each held until taken.
// Throughput: one request at a time; the single relaxation unit and the cost memory's single
// write port set the pace. Reset: synchronous, active low; the sequencer returns to idle and
// node_count returns to 1. The cost matrix holds no defined value until loaded.
// ----------------------------------------------------------------------------
// bellman_ford_dense_matrix
// Single-source shortest paths from node 0 over a dense matrix of signed
// 64-bit edge costs, using repeated relaxation passes.
// ----------------------------------------------------------------------------
module bellman_ford_dense_matrix #(
  parameter int MAX_NODES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfdm_pkg::CFG_W-1:0]  cfg_wdata,
  bfdm_in_if.sink                     in_ch,
  bfdm_out_if.source                  out_ch
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  // The node count is sampled by the sequencer when a start request is
  // taken, so writing it between solves is all that is needed.
  logic [bfdm_pkg::CFG_W-1:0] node_count_r;

  bfdm_pkg::ctrl_t ctrl;
  bfdm_pkg::stat_t stat;
  logic [IW-1:0]   u_idx;
  logic [IW-1:0]   v_idx;
  logic [IW-1:0]   i_idx;
  logic [CW-1:0]   pass_cnt;
  logic            changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bfdm_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // The sequencer walks rows and columns in order: for each row it fetches
  // the row's current best cost, skips the row when that node is still
  // unreached, and otherwise reads each edge and the target's cost, then
  // lets the relaxation unit decide whether to write a smaller cost back.
  // Passes repeat while some cost changed and the completed pass count is below n - 1.
  bfdm_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .node_count (node_count_r),
    .stat       (stat),
    .ctrl       (ctrl),
    .u_idx      (u_idx),
    .v_idx      (v_idx),
    .i_idx      (i_idx),
    .pass_cnt   (pass_cnt),
    .changed    (changed)
  );

  // The datapath holds the matrix, the best-cost and predecessor memories
  // and the result register. When the final pass still changed a cost, the
  // results report a negative loop: zero cost, zero iterations and the
  // predecessors as they stood.
  bfdm_data #(
    .MAX_NODES (MAX_NODES)
  ) u_data (
    .clk             (clk),
    .ctrl            (ctrl),
    .stat            (stat),
    .u_idx           (u_idx),
    .v_idx           (v_idx),
    .i_idx           (i_idx),
    .pass_cnt        (pass_cnt),
    .changed         (changed),
    .ld_src          (in_ch.src_node),
    .ld_dst          (in_ch.dst_node),
    .ld_cost         (in_ch.edge_cost),
    .res_node        (out_ch.node),
    .res_min_cost    (out_ch.min_cost),
    .res_predecessor (out_ch.predecessor),
    .res_iterations  (out_ch.iterations),
    .res_costs_valid (out_ch.costs_valid),
    .res_last        (out_ch.last)
  );

endmodule

@@ hdl/bfdm_chk.sv @@
// ----------------------------------------------------------------------------
// bfdm_chk
// Port-level checks on the solver's request and result channels.
// ----------------------------------------------------------------------------
module bfdm_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [bfdm_pkg::COST_W-1:0] out_min_cost,
  input logic        [bfdm_pkg::ITER_W-1:0] out_iterations,
  input logic                               out_costs_valid,
  input logic                               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_cost) && $stable(out_last))
    else $error("result changed while stalled");

  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while results are pending");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("became ready before the final result");

  a_neg_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_costs_valid |-> out_min_cost == '0 && out_iterations == '0)
    else $error("negative loop result carries a cost or count");

  a_conv_iter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_costs_valid |-> out_iterations != '0)
    else $error("converged result with zero iterations");

endmodule

bind bellman_ford_dense_matrix bfdm_chk u_bfdm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_min_cost    (out_ch.min_cost),
  .out_iterations  (out_ch.iterations),
  .out_costs_valid (out_ch.costs_valid),
  .out_last        (out_ch.last)
);
